/* rtl/pfp_pkg.sv */
// package for the particulate frame parser: constants, frame positions, shared types
package pfp_pkg;

  localparam int unsigned FRAME_BYTES = 10;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  localparam int unsigned CNT_W       = 16;

  localparam logic [7:0] START_BYTE   = 8'hAA;
  localparam logic [7:0] COMMAND_BYTE = 8'hC0;
  localparam logic [7:0] TAIL_BYTE    = 8'hAB;

  localparam logic [POS_W-1:0] POS_START     = POS_W'(0);
  localparam logic [POS_W-1:0] POS_COMMAND   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_FINE_LO   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_FINE_HI   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_COARSE_LO = POS_W'(4);
  localparam logic [POS_W-1:0] POS_COARSE_HI = POS_W'(5);
  localparam logic [POS_W-1:0] POS_LAST_DATA = POS_W'(7);
  localparam logic [POS_W-1:0] POS_CHECKSUM  = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_TAIL      = POS_W'(FRAME_BYTES - 1);

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_error;
  } pfp_item_t;

  typedef struct packed {
    logic [15:0]      fine_dust;
    logic [15:0]      coarse_dust;
    logic             frame_accepted;
    logic [CNT_W-1:0] good_frames;
    logic [CNT_W-1:0] bytes_seen;
  } pfp_result_t;

endpackage

/* rtl/pfp_byte_if.sv */
// received-byte channel: valid/ready handshake with byte and line-error flag
interface pfp_byte_if import pfp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       line_error;

  modport source (output valid, output rx_byte, output line_error, input ready);
  modport sink   (input valid, input rx_byte, input line_error, output ready);
endinterface

/* rtl/pfp_result_if.sv */
// result channel: valid/ready handshake with readings, accept flag and counters
interface pfp_result_if import pfp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [15:0]      fine_dust;
  logic [15:0]      coarse_dust;
  logic             frame_accepted;
  logic [CNT_W-1:0] good_frames;
  logic [CNT_W-1:0] bytes_seen;

  modport source (output valid, output fine_dust, output coarse_dust, output frame_accepted,
                  output good_frames, output bytes_seen, input ready);
  modport sink   (input valid, input fine_dust, input coarse_dust, input frame_accepted,
                  input good_frames, input bytes_seen, output ready);
endinterface

/* rtl/particulate_frame_parser.sv */
// top level of the particulate frame parser: input register, tracker, result register
//
// usage:
//   rx   : one transaction per received serial byte, with its line-error flag
//   meas : one transaction per accepted byte, carrying the latest published
//          fine and coarse readings, a flag set when that byte completed a
//          frame with correct tail and checksum, and both 16-bit counters
//   each byte enters an input register, is evaluated combinationally against the
//   frame tracker state, and lands in the result register; the result is valid
//   once the byte has passed both registers
//   throughput is one byte per cycle while meas does not stall, set by the
//   joint update of the position, running checksum and counters in the tracker
//   when meas stalls, the input register still takes one more byte, then rx
//   ready drops until the result register is taken; nothing is lost or repeated
//   reset (rst, synchronous) empties both registers, returns the hunt to the
//   start byte and clears readings and counters
//   no clearing pass after reset
module particulate_frame_parser import pfp_pkg::*; (
  input logic           clk,
  input logic           rst,
  pfp_byte_if.sink      rx,
  pfp_result_if.source  meas
);

  logic        in_valid;
  pfp_item_t   in_item;
  logic        out_valid;
  pfp_result_t out_result;
  pfp_result_t result;
  logic        advance;

  assign advance  = in_valid && (!out_valid || meas.ready);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_item.rx_byte    <= rx.rx_byte;
      in_item.line_error <= rx.line_error;
    end
  end

  pfp_frame_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || meas.ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign meas.valid          = out_valid;
  assign meas.fine_dust      = out_result.fine_dust;
  assign meas.coarse_dust    = out_result.coarse_dust;
  assign meas.frame_accepted = out_result.frame_accepted;
  assign meas.good_frames    = out_result.good_frames;
  assign meas.bytes_seen     = out_result.bytes_seen;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !meas.ready |-> !rx.ready)
    else $error("input taken while pipeline is full");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("evaluated byte produced no result");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !meas.ready |=> out_valid && $stable(out_result))
    else $error("stalled result changed");

endmodule

/* rtl/pfp_frame_tracker.sv */
// frame tracker: position, running checksum, captured readings and counters
module pfp_frame_tracker import pfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  pfp_item_t   item,
  output pfp_result_t result
);

  logic [POS_W-1:0] position, position_next;
  logic [7:0]       checksum, checksum_next;
  logic             checksum_ok, checksum_ok_next;
  logic [7:0]       fine_lo, fine_hi, coarse_lo, coarse_hi;
  logic [15:0]      fine_reading, fine_reading_next;
  logic [15:0]      coarse_reading, coarse_reading_next;
  logic [CNT_W-1:0] good_frame_count, good_frame_count_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             accepted;

  always_comb begin
    position_next         = position;
    checksum_next         = checksum;
    checksum_ok_next      = checksum_ok;
    fine_reading_next     = fine_reading;
    coarse_reading_next   = coarse_reading;
    good_frame_count_next = good_frame_count;
    byte_count_next       = byte_count + CNT_W'(1);
    accepted              = 1'b0;
    if (item.line_error) begin
      position_next = POS_START;
    end else if (position == POS_START) begin
      if (item.rx_byte == START_BYTE) position_next = POS_COMMAND;
    end else if (position == POS_COMMAND) begin
      position_next = (item.rx_byte == COMMAND_BYTE) ? POS_FINE_LO : POS_START;
    end else begin
      position_next = position + POS_W'(1);
      case (position) inside
        POS_FINE_LO: begin
          checksum_next = item.rx_byte;
        end
        [POS_FINE_HI:POS_LAST_DATA]: begin
          checksum_next = checksum + item.rx_byte;
        end
        POS_CHECKSUM: begin
          checksum_ok_next = (checksum == item.rx_byte);
        end
        POS_TAIL: begin
          position_next = POS_START;
          if (item.rx_byte == TAIL_BYTE && checksum_ok) begin
            accepted              = 1'b1;
            fine_reading_next     = {fine_hi, fine_lo};
            coarse_reading_next   = {coarse_hi, coarse_lo};
            good_frame_count_next = good_frame_count + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position         <= POS_START;
      fine_reading     <= '0;
      coarse_reading   <= '0;
      good_frame_count <= '0;
      byte_count       <= '0;
    end else if (advance) begin
      position         <= position_next;
      fine_reading     <= fine_reading_next;
      coarse_reading   <= coarse_reading_next;
      good_frame_count <= good_frame_count_next;
      byte_count       <= byte_count_next;
    end
  end

  // frame payload, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      checksum    <= checksum_next;
      checksum_ok <= checksum_ok_next;
      if (!item.line_error) begin
        if (position == POS_FINE_LO)   fine_lo   <= item.rx_byte;
        if (position == POS_FINE_HI)   fine_hi   <= item.rx_byte;
        if (position == POS_COARSE_LO) coarse_lo <= item.rx_byte;
        if (position == POS_COARSE_HI) coarse_hi <= item.rx_byte;
      end
    end
  end

  assign result.fine_dust      = fine_reading_next;
  assign result.coarse_dust    = coarse_reading_next;
  assign result.frame_accepted = accepted;
  assign result.good_frames    = good_frame_count_next;
  assign result.bytes_seen     = byte_count_next;

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    position <= POS_TAIL)
    else $error("frame position out of range");

  a_error_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && item.line_error |=> position == POS_START)
    else $error("line error did not restart the hunt");

  a_accept_at_tail: assert property (@(posedge clk) disable iff (rst)
    accepted |-> position == POS_TAIL && !item.line_error)
    else $error("frame accepted away from tail position");

  a_byte_count_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> byte_count == $past(byte_count) + CNT_W'(1))
    else $error("byte counter did not advance");

  a_good_count_hold: assert property (@(posedge clk) disable iff (rst)
    advance && !accepted |=> good_frame_count == $past(good_frame_count))
    else $error("valid-frame counter moved without an accepted frame");

endmodule
